// ----- hdl/gdc_pkg.sv -----
`default_nettype none

package gdc_pkg;

    // Field widths fixed by the stream format.
    localparam int READING_WIDTH = 16;
    localparam int ERROR_WIDTH   = 24;
    localparam int TIME_WIDTH    = 32;
    localparam int ANGLE_WIDTH   = 21;

    // Configuration register widths and reset values.
    localparam int INTERVAL_WIDTH  = 16;
    localparam int THRESHOLD_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [INTERVAL_WIDTH-1:0]  CHECK_INTERVAL_RESET  = 16'd250;
    localparam logic [THRESHOLD_WIDTH-1:0] DRIFT_THRESHOLD_RESET = 8'd3;

    // Register indexes on the configuration channel.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CHECK_INTERVAL  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DRIFT_THRESHOLD = 2'd1;

    // Readings come in tenths of a degree; one wrap by a full turn.
    localparam int TENTHS    = 10;
    localparam int FULL_TURN = 360;

endpackage

`default_nettype wire

// ----- hdl/gyro_drift_compensator.sv -----
`default_nettype none

// Channel      | Direction | Handshake                  | Payload
// -------------+-----------+----------------------------+-----------------------------------
// s_axis       | in        | i_s_axis_tvalid/o_..tready | raw_reading, timestamp_ms
// m_axis       | out       | o_m_axis_tvalid/i_..tready | angle_deg
// cfg          | in        | i_cfg_valid/o_cfg_ready    | register index, write data
//
// The datapath is a four-stage pipeline: input register, drift update and sum,
// reciprocal multiply for the divide by ten, then correction and wrap into the
// output register. One item is taken every cycle unless a stall on the output
// side fills the pipeline; the drift state lives in the second stage, so
// consecutive items see each other's updates in order.
// Reset is synchronous and active low; it clears all valid bits and the drift
// state and returns the configuration registers to their default values. A stall
// on the output side backs up only as far as the first empty stage, so bubbles
// are absorbed.

module gyro_drift_compensator #(
    parameter int READING_WIDTH = gdc_pkg::READING_WIDTH,
    parameter int ERROR_WIDTH   = gdc_pkg::ERROR_WIDTH,
    localparam int IN_TDATA_WIDTH =
        ((READING_WIDTH + gdc_pkg::TIME_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_WIDTH = ((gdc_pkg::ANGLE_WIDTH + 7) / 8) * 8
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,

    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // Fields from bit 0 up: raw_reading, timestamp_ms, zero fill.
    input  wire  [IN_TDATA_WIDTH-1:0]           i_s_axis_tdata,

    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    // Fields from bit 0 up: angle_deg, zero fill.
    output logic [OUT_TDATA_WIDTH-1:0]          o_m_axis_tdata,

    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [gdc_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire  [gdc_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    localparam int RW = READING_WIDTH;
    localparam int EW = ERROR_WIDTH;
    localparam int TW = gdc_pkg::TIME_WIDTH;
    localparam int OW = gdc_pkg::ANGLE_WIDTH;
    localparam int IW = gdc_pkg::INTERVAL_WIDTH;
    localparam int HW = gdc_pkg::THRESHOLD_WIDTH;
    // Accumulator update width, sum width and signed quotient width.
    localparam int SW = ((EW > RW + 1) ? EW : RW + 1) + 1;
    localparam int AW = ((EW > RW) ? EW : RW) + 1;
    localparam int QW = ((AW > OW) ? AW : OW) + 1;

    localparam logic signed [SW-1:0] ERR_MAX = SW'({1'b0, {(EW - 1){1'b1}}});
    localparam logic signed [EW-1:0] ERR_MIN_E = {1'b1, {(EW - 1){1'b0}}};
    localparam logic signed [SW-1:0] ERR_MIN = SW'(ERR_MIN_E);
    // floor(2^AW / 10): the product shifted by AW is the quotient or one less.
    localparam logic [AW-1:0] RECIP = AW'((64'd1 << AW) / 64'(gdc_pkg::TENTHS));
    localparam logic [AW+3:0] TEN_W = (AW + 4)'(gdc_pkg::TENTHS);
    localparam logic signed [QW-1:0] TURN = QW'(gdc_pkg::FULL_TURN);

    // Configuration registers. Writes are always taken.
    logic [IW-1:0] r_check_interval;
    logic [HW-1:0] r_drift_threshold;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_interval  <= gdc_pkg::CHECK_INTERVAL_RESET;
            r_drift_threshold <= gdc_pkg::DRIFT_THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gdc_pkg::CFG_CHECK_INTERVAL: begin
                    r_check_interval <= i_cfg_data[IW-1:0];
                end
                gdc_pkg::CFG_DRIFT_THRESHOLD: begin
                    r_drift_threshold <= i_cfg_data[HW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Stage enables: a stage moves when the one after it is empty or moving.
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_s3_valid;
    logic r_out_valid;
    logic w_en_out;
    logic w_en_s3;
    logic w_en_s2;
    logic w_en_s1;

    assign w_en_out        = !r_out_valid || i_m_axis_tready;
    assign w_en_s3         = !r_s3_valid || w_en_out;
    assign w_en_s2         = !r_s2_valid || w_en_s3;
    assign w_en_s1         = !r_s1_valid || w_en_s2;
    assign o_s_axis_tready = w_en_s1;
    assign o_m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en_s1) begin
                r_s1_valid <= i_s_axis_tvalid;
            end
            if (w_en_s2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_en_s3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (w_en_out) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    // Stage 1: input register.
    logic signed [RW-1:0] r_s1_reading;
    logic [TW-1:0]        r_s1_time;

    always_ff @(posedge i_clk) begin
        if (w_en_s1 && i_s_axis_tvalid) begin
            r_s1_reading <= i_s_axis_tdata[RW-1:0];
            r_s1_time    <= i_s_axis_tdata[RW+TW-1:RW];
        end
    end

    // Stage 2: drift check against the last check point, then reading plus
    // the (possibly updated) accumulator.
    logic signed [EW-1:0] r_drift_error;
    logic signed [RW-1:0] r_last_reading;
    logic [TW-1:0]        r_last_time;
    logic signed [AW-1:0] r_total;

    logic [TW-1:0]        w_elapsed;
    logic                 w_check;
    logic signed [RW:0]   w_change;
    logic [RW:0]          w_change_mag;
    logic                 w_is_drift;
    logic signed [SW-1:0] w_acc_sum;
    logic signed [EW-1:0] w_acc_sat;
    logic signed [EW-1:0] w_new_drift;
    logic                 w_s2_take;

    assign w_s2_take = r_s1_valid && w_en_s2;
    assign w_elapsed = r_s1_time - r_last_time;
    assign w_check   = w_elapsed > TW'(r_check_interval);
    assign w_change  = (RW + 1)'(r_last_reading) - (RW + 1)'(r_s1_reading);
    assign w_change_mag = w_change[RW] ? (RW + 1)'(-w_change) : (RW + 1)'(w_change);
    assign w_is_drift   = w_change_mag < (RW + 1)'(r_drift_threshold);
    assign w_acc_sum    = SW'(r_drift_error) + SW'(w_change);

    always_comb begin
        if (w_acc_sum > ERR_MAX) begin
            w_acc_sat = ERR_MAX[EW-1:0];
        end else if (w_acc_sum < ERR_MIN) begin
            w_acc_sat = ERR_MIN_E;
        end else begin
            w_acc_sat = w_acc_sum[EW-1:0];
        end
    end

    assign w_new_drift = (w_check && w_is_drift) ? w_acc_sat : r_drift_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drift_error  <= '0;
            r_last_reading <= '0;
            r_last_time    <= '0;
        end else if (w_s2_take && w_check) begin
            r_drift_error  <= w_new_drift;
            r_last_reading <= r_s1_reading;
            r_last_time    <= r_s1_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_take) begin
            r_total <= AW'(r_s1_reading) + AW'(w_new_drift);
        end
    end

    // Stage 3: magnitude times the reciprocal of ten.
    logic [AW-1:0]   w_abs;
    logic [2*AW-1:0] w_product;
    logic [AW-1:0]   r_abs;
    logic [AW-1:0]   r_q0;
    logic            r_neg;

    assign w_abs     = r_total[AW-1] ? AW'(-r_total) : AW'(r_total);
    assign w_product = (2 * AW)'(w_abs) * (2 * AW)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && w_en_s3) begin
            r_abs <= w_abs;
            r_q0  <= w_product[2*AW-1:AW];
            r_neg <= r_total[AW-1];
        end
    end

    // Stage 4: bump the estimate if the remainder reaches ten, restore the
    // sign (truncation toward zero), then one wrap by a full turn.
    logic [AW+3:0]        w_q0_x10;
    logic [AW+3:0]        w_rem;
    logic [AW-1:0]        w_quot_mag;
    logic signed [QW-1:0] w_quot;
    logic signed [QW-1:0] w_wrapped;
    logic [OW-1:0]        r_angle;

    assign w_q0_x10   = ((AW + 4)'(r_q0) << 3) + ((AW + 4)'(r_q0) << 1);
    assign w_rem      = (AW + 4)'(r_abs) - w_q0_x10;
    assign w_quot_mag = (w_rem >= TEN_W) ? r_q0 + AW'(1) : r_q0;
    assign w_quot     = r_neg ? -QW'(w_quot_mag) : QW'(w_quot_mag);

    always_comb begin
        if (w_quot < -TURN) begin
            w_wrapped = w_quot + TURN;
        end else if (w_quot > TURN) begin
            w_wrapped = w_quot - TURN;
        end else begin
            w_wrapped = w_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_valid && w_en_out) begin
            r_angle <= w_wrapped[OW-1:0];
        end
    end

    assign o_m_axis_tdata = OUT_TDATA_WIDTH'(r_angle);

endmodule

`default_nettype wire
